/* hdl/pvcsd_pkg.sv */
// Shared types and constants of the PCM versus coded stream detector.
`default_nettype none
package pvcsd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int MINFR_W  = 17;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_AVERAGE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCK_FRAMES   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd12000;
  localparam logic [MINFR_W-1:0] MIN_FR_RESET  = 17'd1000;
  localparam logic signed [SAMPLE_W-1:0] SILENCE_LEVEL = 16'sd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic is_pcm;
    logic mute;
  } verdict_t;

endpackage
`default_nettype wire

/* hdl/pvcsd_if.sv */
// Valid/ready channel interfaces for frames in and verdicts out.
`default_nettype none
interface pvcsd_in_if
  import pvcsd_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_frame;

  modport source (output valid, output sample, output last_frame, input ready);
  modport sink   (input valid, input sample, input last_frame, output ready);
endinterface

interface pvcsd_out_if;
  logic valid;
  logic ready;
  logic is_pcm;
  logic mute;

  modport source (output valid, output is_pcm, output mute, input ready);
  modport sink   (input valid, input is_pcm, input mute, output ready);
endinterface
`default_nettype wire

/* hdl/pvcsd_verdict.sv */
// Block verdict: frame-count check and sum < limit * count test.
`default_nettype none
module pvcsd_verdict
  import pvcsd_pkg::*;
#(
  parameter int CNT_W = 17,
  parameter int SUM_W = 32
) (
  input  wire logic [SUM_W-1:0]   sum_i,
  input  wire logic [CNT_W-1:0]   gated_i,
  input  wire logic [CNT_W-1:0]   frames_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  input  wire logic [MINFR_W-1:0] min_i,
  output verdict_t                verdict_o
);

  localparam int CMP_W  = (CNT_W > MINFR_W) ? CNT_W : MINFR_W;
  localparam int PROD_W = LIMIT_W + CNT_W;

  logic [PROD_W-1:0] prod;
  logic              short_blk;
  logic              below;

  always_comb begin
    prod      = PROD_W'(limit_i) * PROD_W'(gated_i);
    short_blk = CMP_W'(frames_i) < CMP_W'(min_i);
    // sum always fits below the product width
    below     = PROD_W'(sum_i) < prod;
    verdict_o.mute   = short_blk;
    verdict_o.is_pcm = !short_blk && below;
  end

endmodule
`default_nettype wire

/* hdl/pcm_vs_coded_stream_detector.sv */
// Top level of the PCM versus coded stream detector.
//
// Takes one channel-0 sample per transaction and sums the absolute step between
// successive samples of a block, counting a step only when both samples are
// louder than the silence level of 2 (the count starts at 1, the first frame
// steps against itself). The transaction flagged last_frame closes the block
// and yields one verdict transaction: mute=1, is_pcm=0 if the block held fewer
// than min_block_frames frames, else is_pcm=1 when sum < limit * count. All
// other frames yield nothing. One frame per clock is taken unless a block
// snapshot is pending; the verdict passes through the block snapshot register,
// then the output register. The frame counter and step counter saturate at
// MAX_BLOCK_FRAMES. Configuration writes (index 0: diff_average_limit, index 1:
// min_block_frames) must happen with the block idle.
`default_nettype none
module pcm_vs_coded_stream_detector
  import pvcsd_pkg::*;
#(
  parameter int MAX_BLOCK_FRAMES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  pvcsd_in_if.sink                  in_ch,
  pvcsd_out_if.source               out_ch
);

  localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);
  // each step is at most 65535 and at most MAX-1 steps are summed
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_BLOCK_FRAMES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_FRAMES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // config registers
  logic [LIMIT_W-1:0] limit_r;
  logic [MINFR_W-1:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      min_r   <= MIN_FR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_AVERAGE_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_MIN_BLOCK_FRAMES:   min_r   <= cfg_wdata[MINFR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: verdict register -> output register
  logic dec_valid_r;
  logic out_valid_r;
  logic out_take;
  logic dec_move;
  logic in_acc;

  assign out_take     = !out_valid_r || out_ch.ready;
  assign dec_move     = dec_valid_r && out_take;
  assign in_ch.ready  = !dec_valid_r || dec_move;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // block accumulator
  sample_t          prev_r;
  logic             first_r;
  logic [CNT_W-1:0] frames_r;
  logic [CNT_W-1:0] gated_r;
  logic [SUM_W-1:0] sum_r;

  sample_t             prev_eff;
  logic signed [16:0]  diff;
  logic [15:0]         step;
  logic                loud_prev;
  logic                loud_cur;
  logic                gate;
  logic [CNT_W-1:0]    frames_nxt;
  logic [CNT_W-1:0]    gated_nxt;
  logic [SUM_W-1:0]    sum_nxt;

  always_comb begin
    prev_eff  = first_r ? in_ch.sample : prev_r;
    loud_prev = (prev_eff > SILENCE_LEVEL) || (prev_eff < -SILENCE_LEVEL);
    loud_cur  = (in_ch.sample > SILENCE_LEVEL) || (in_ch.sample < -SILENCE_LEVEL);
    diff      = {prev_eff[15], prev_eff} - {in_ch.sample[15], in_ch.sample};
    step      = diff[16] ? 16'(-diff) : diff[15:0];
    gate      = loud_prev && loud_cur && (gated_r < CNT_MAX);
    sum_nxt   = gate ? sum_r + SUM_W'(step) : sum_r;
    gated_nxt = gate ? gated_r + CNT_ONE : gated_r;
    frames_nxt = (frames_r < CNT_MAX) ? frames_r + CNT_ONE : frames_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      frames_r <= '0;
      gated_r  <= CNT_ONE;
      sum_r    <= '0;
    end else if (in_acc) begin
      if (in_ch.last_frame) begin
        // block closed: restart for the next one
        first_r  <= 1'b1;
        frames_r <= '0;
        gated_r  <= CNT_ONE;
        sum_r    <= '0;
      end else begin
        first_r  <= 1'b0;
        frames_r <= frames_nxt;
        gated_r  <= gated_nxt;
        sum_r    <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_r <= in_ch.sample;
    end
  end

  // snapshot of a closed block, waiting for the verdict stage
  logic [CNT_W-1:0] dec_frames_r;
  logic [CNT_W-1:0] dec_gated_r;
  logic [SUM_W-1:0] dec_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_frame) begin
      dec_valid_r <= 1'b1;
    end else if (dec_move) begin
      dec_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_frame) begin
      dec_frames_r <= frames_nxt;
      dec_gated_r  <= gated_nxt;
      dec_sum_r    <= sum_nxt;
    end
  end

  verdict_t verdict;

  pvcsd_verdict #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_verdict (
    .sum_i     (dec_sum_r),
    .gated_i   (dec_gated_r),
    .frames_i  (dec_frames_r),
    .limit_i   (limit_r),
    .min_i     (min_r),
    .verdict_o (verdict)
  );

  // output register
  verdict_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= dec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_move) begin
      out_r <= verdict;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.is_pcm = out_r.is_pcm;
  assign out_ch.mute   = out_r.mute;

`ifndef SYNTH
  // a verdict is never both PCM and muted
  a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.is_pcm && out_r.mute))
    else $error("verdict both is_pcm and mute");

  // closing a block restarts the accumulator
  a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_frame) |=> (first_r && gated_r == CNT_ONE && sum_r == '0
                                       && frames_r == '0 && dec_valid_r))
    else $error("accumulator not restarted after last frame");

  // frames inside a block count up until saturation
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.last_frame && frames_r < CNT_MAX)
      |=> frames_r == $past(frames_r) + CNT_ONE)
    else $error("frame count did not advance");

  // a pending block snapshot stalls the input until it moves on
  a_snapshot_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_valid_r && !dec_move) |-> !in_ch.ready)
    else $error("input taken over a pending snapshot");

  // step count never passes its bound
  a_gated_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gated_r <= CNT_MAX && gated_r != '0)
    else $error("step count out of range");
`endif

endmodule
`default_nettype wire
